@@ rtl/core/crcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// crcfr_pkg
// shared constants, types and step functions of the forward/reverse table crc
// ----------------------------------------------------------------------------
package crcfr_pkg;

  localparam int WORD_W        = 32;
  localparam int BYTE_W        = 8;
  localparam int TBL_DEPTH     = 256;
  localparam int TBL_IDX_W     = 8;
  localparam int SHIFT_W       = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CRC_WIDTH_W   = 6;
  localparam int REG_BYTES_W   = 3;
  localparam int MAX_WIDTH_DEF = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CRC_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REG_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST = 2'd2;

  // reset values of the configuration registers
  localparam logic [CRC_WIDTH_W-1:0] CRC_WIDTH_RESET = 6'd32;
  localparam logic [REG_BYTES_W-1:0] REG_BYTES_RESET = 3'd4;
  localparam logic                   MSB_FIRST_RESET = 1'b0;

  typedef enum logic [1:0] {
    KIND_LOAD_FWD = 2'd0,
    KIND_LOAD_REV = 2'd1,
    KIND_FWD_BYTE = 2'd2,
    KIND_REV_BYTE = 2'd3
  } kind_e;

  typedef struct packed {
    logic [WORD_W-1:0]  mask;
    logic [SHIFT_W-1:0] shift;
    logic               msb_first;
  } cfg_t;

  // table address for one byte step
  function automatic logic [TBL_IDX_W-1:0] step_index(
    input logic               rev,
    input logic               msb,
    input logic [WORD_W-1:0]  r,
    input logic [BYTE_W-1:0]  d,
    input logic [SHIFT_W-1:0] s
  );
    logic [WORD_W-1:0] r_top;
    logic [TBL_IDX_W-1:0] idx;
    r_top = r >> s;
    if (!rev) begin
      idx = msb ? (d ^ r_top[TBL_IDX_W-1:0]) : (d ^ r[TBL_IDX_W-1:0]);
    end else begin
      idx = msb ? r[TBL_IDX_W-1:0] : r_top[TBL_IDX_W-1:0];
    end
    return idx;
  endfunction

  // register value after one byte step, masked to the crc width
  function automatic logic [WORD_W-1:0] step_next(
    input logic               rev,
    input logic               msb,
    input logic [WORD_W-1:0]  r,
    input logic [BYTE_W-1:0]  d,
    input logic [WORD_W-1:0]  tw,
    input logic [SHIFT_W-1:0] s,
    input logic [WORD_W-1:0]  mask
  );
    logic [WORD_W-1:0] d_w;
    logic [WORD_W-1:0] nxt;
    d_w = WORD_W'(d);
    if (!rev) begin
      nxt = msb ? (tw ^ (r << BYTE_W)) : (tw ^ (r >> BYTE_W));
    end else if (msb) begin
      nxt = (d_w << s) ^ tw ^ (r << s) ^ (r >> BYTE_W);
    end else begin
      nxt = d_w ^ tw ^ (r << BYTE_W);
    end
    return nxt & mask;
  endfunction

endpackage

@@ rtl/core/crcfr_in_if.sv @@
// ----------------------------------------------------------------------------
// crcfr_in_if
// request channel carrying table loads and message bytes
// ----------------------------------------------------------------------------
interface crcfr_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic [crcfr_pkg::TBL_IDX_W-1:0]     table_index;
  logic [crcfr_pkg::WORD_W-1:0]        table_word;
  logic [crcfr_pkg::BYTE_W-1:0]        data_byte;
  logic                                first_byte;
  logic                                last_byte;
  logic [crcfr_pkg::WORD_W-1:0]        seed_value;

  modport source (
    output valid, kind, table_index, table_word, data_byte, first_byte, last_byte,
           seed_value,
    input  ready
  );
  modport sink (
    input  valid, kind, table_index, table_word, data_byte, first_byte, last_byte,
           seed_value,
    output ready
  );
endinterface

@@ rtl/core/crcfr_out_if.sv @@
// ----------------------------------------------------------------------------
// crcfr_out_if
// result channel carrying the crc value at the end of a run
// ----------------------------------------------------------------------------
interface crcfr_out_if;
  logic                         valid;
  logic                         ready;
  logic [crcfr_pkg::WORD_W-1:0] crc_value;

  modport source (output valid, crc_value, input ready);
  modport sink (input valid, crc_value, output ready);
endinterface

@@ rtl/core/crcfr_cfg_if.sv @@
// ----------------------------------------------------------------------------
// crcfr_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface crcfr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [crcfr_pkg::CFG_IDX_W-1:0] index;
  logic [crcfr_pkg::WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/crcfr_cfg.sv @@
// ----------------------------------------------------------------------------
// crcfr_cfg
// configuration registers, kept as a ready-made mask and top-byte shift
// ----------------------------------------------------------------------------
module crcfr_cfg #(
  parameter int MAX_WIDTH = crcfr_pkg::MAX_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  crcfr_cfg_if.sink           cfg_i,
  output crcfr_pkg::cfg_t     cfg_o
);
  import crcfr_pkg::*;

  localparam int BYTES_MAX = MAX_WIDTH / 8;

  function automatic logic [WORD_W-1:0] width_mask(input logic [CRC_WIDTH_W-1:0] w);
    logic [CRC_WIDTH_W-1:0] wc;
    wc = (w > CRC_WIDTH_W'(MAX_WIDTH)) ? CRC_WIDTH_W'(MAX_WIDTH) : w;
    return ~({WORD_W{1'b1}} << wc);
  endfunction

  function automatic logic [SHIFT_W-1:0] top_shift(input logic [REG_BYTES_W-1:0] b);
    logic [REG_BYTES_W-1:0] bc;
    logic [REG_BYTES_W-1:0] bm1;
    bc = b;
    if (bc < REG_BYTES_W'(1)) bc = REG_BYTES_W'(1);
    if (bc > REG_BYTES_W'(BYTES_MAX)) bc = REG_BYTES_W'(BYTES_MAX);
    bm1 = bc - REG_BYTES_W'(1);
    return {bm1[1:0], 3'b000};
  endfunction

  logic [WORD_W-1:0]  mask_q;
  logic [SHIFT_W-1:0] shift_q;
  logic               msb_q;
  logic               wr;

  assign cfg_i.ready = 1'b1;
  assign wr = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= width_mask(CRC_WIDTH_RESET);
      shift_q <= top_shift(REG_BYTES_RESET);
      msb_q   <= MSB_FIRST_RESET;
    end else if (wr) begin
      unique case (cfg_i.index)
        REG_CRC_WIDTH: mask_q  <= width_mask(cfg_i.data[CRC_WIDTH_W-1:0]);
        REG_REG_BYTES: shift_q <= top_shift(cfg_i.data[REG_BYTES_W-1:0]);
        REG_MSB_FIRST: msb_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.mask      = mask_q;
  assign cfg_o.shift     = shift_q;
  assign cfg_o.msb_first = msb_q;

endmodule

@@ rtl/core/crcfr_ram.sv @@
// ----------------------------------------------------------------------------
// crcfr_ram
// single-port table memory with registered read data
// ----------------------------------------------------------------------------
module crcfr_ram #(
  parameter int DATA_W = crcfr_pkg::MAX_WIDTH_DEF,
  parameter int DEPTH  = crcfr_pkg::TBL_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/crc_table_step_forward_reverse.sv @@
// ----------------------------------------------------------------------------
// crc_table_step_forward_reverse
// byte-at-a-time table crc, stepping forwards or backwards through a message
// ----------------------------------------------------------------------------
// path: a byte is held in stage 1, then in stage 2 with its table read, then in the result register
// throughput: one item per cycle, loads and bytes alike, unless a result is blocked;
//   the loop is table read data -> next register value -> next table address, via the ram's output
// reset: control state and running register cleared, config 32 bits, 4 bytes,
//   reflected form; the tables are not cleared and read as garbage until loaded
module crc_table_step_forward_reverse #(
  parameter int MAX_WIDTH = crcfr_pkg::MAX_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  crcfr_in_if.sink     in_i,
  crcfr_out_if.source  out_o,
  crcfr_cfg_if.sink    cfg_i
);
  import crcfr_pkg::*;

  // configuration
  cfg_t cfg;

  crcfr_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // stage 1: input register, table access is issued from here
  logic                 s1_valid_q;
  kind_e                s1_kind_q;
  logic [TBL_IDX_W-1:0] s1_index_q;
  logic [WORD_W-1:0]    s1_word_q;
  logic [BYTE_W-1:0]    s1_data_q;
  logic                 s1_first_q;
  logic                 s1_last_q;
  logic [WORD_W-1:0]    s1_seed_q;

  // stage 2: byte step waiting for its table word
  logic                 s2_valid_q;
  logic                 s2_rev_q;
  logic                 s2_last_q;
  logic [WORD_W-1:0]    s2_r_q;
  logic [BYTE_W-1:0]    s2_data_q;

  // running register and result register
  logic [MAX_WIDTH-1:0] run_q;
  logic                 out_valid_q;
  logic [WORD_W-1:0]    out_crc_q;

  logic [MAX_WIDTH-1:0] fwd_rdata;
  logic [MAX_WIDTH-1:0] rev_rdata;
  logic [WORD_W-1:0]    s2_tw;
  logic [WORD_W-1:0]    s2_next;
  logic [MAX_WIDTH-1:0] s2_next_w;
  logic                 s2_step;
  logic [MAX_WIDTH-1:0] r_run;
  logic                 s1_byte;
  logic                 s1_rev;
  logic [WORD_W-1:0]    s1_r;
  logic [TBL_IDX_W-1:0] s1_idx;
  logic                 stall;
  logic                 adv;
  logic                 go;
  logic                 fwd_en;
  logic                 fwd_we;
  logic                 rev_en;
  logic                 rev_we;
  logic [TBL_IDX_W-1:0] ram_addr;

  // finish the step in stage 2 from the registered table word
  assign s2_tw     = s2_rev_q ? WORD_W'(rev_rdata) : WORD_W'(fwd_rdata);
  assign s2_next   = step_next(s2_rev_q, cfg.msb_first, s2_r_q, s2_data_q, s2_tw,
                               cfg.shift, cfg.mask);
  assign s2_next_w = s2_next[MAX_WIDTH-1:0];
  assign s2_step   = s2_valid_q;

  // bypass: the byte in stage 1 sees the value stage 2 is producing
  assign r_run   = s2_step ? s2_next_w : run_q;
  assign s1_byte = (s1_kind_q == KIND_FWD_BYTE) || (s1_kind_q == KIND_REV_BYTE);
  assign s1_rev  = (s1_kind_q == KIND_REV_BYTE);
  assign s1_r    = s1_first_q ? s1_seed_q : WORD_W'(r_run);
  assign s1_idx  = step_index(s1_rev, cfg.msb_first, s1_r, s1_data_q, cfg.shift);

  // hold the whole pipe only when a result has nowhere to go
  assign stall      = s2_step && s2_last_q && out_valid_q && !out_o.ready;
  assign adv        = !stall;
  assign go         = adv && s1_valid_q;
  assign in_i.ready = !s1_valid_q || adv;

  // one table access per item: a load writes, a byte reads
  always_comb begin
    fwd_en   = 1'b0;
    fwd_we   = 1'b0;
    rev_en   = 1'b0;
    rev_we   = 1'b0;
    ram_addr = s1_index_q;
    unique case (s1_kind_q)
      KIND_LOAD_FWD: begin
        fwd_en = go;
        fwd_we = go;
      end
      KIND_LOAD_REV: begin
        rev_en = go;
        rev_we = go;
      end
      KIND_FWD_BYTE: begin
        fwd_en   = go;
        ram_addr = s1_idx;
      end
      KIND_REV_BYTE: begin
        rev_en   = go;
        ram_addr = s1_idx;
      end
      default: ;
    endcase
  end

  crcfr_ram #(.DATA_W(MAX_WIDTH), .DEPTH(TBL_DEPTH)) u_fwd_tbl (
    .clk_i   (clk_i),
    .en_i    (fwd_en),
    .we_i    (fwd_we),
    .addr_i  (ram_addr),
    .wdata_i (s1_word_q[MAX_WIDTH-1:0]),
    .rdata_o (fwd_rdata)
  );

  crcfr_ram #(.DATA_W(MAX_WIDTH), .DEPTH(TBL_DEPTH)) u_rev_tbl (
    .clk_i   (clk_i),
    .en_i    (rev_en),
    .we_i    (rev_we),
    .addr_i  (ram_addr),
    .wdata_i (s1_word_q[MAX_WIDTH-1:0]),
    .rdata_o (rev_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      run_q       <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (adv) begin
        s2_valid_q <= s1_valid_q && s1_byte;
        if (s2_step) begin
          run_q <= s2_next_w;
        end
      end
      if (adv && s2_step && s2_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_kind_q  <= kind_e'(in_i.kind);
      s1_index_q <= in_i.table_index;
      s1_word_q  <= in_i.table_word;
      s1_data_q  <= in_i.data_byte;
      s1_first_q <= in_i.first_byte;
      s1_last_q  <= in_i.last_byte;
      s1_seed_q  <= in_i.seed_value;
    end
    if (go && s1_byte) begin
      s2_rev_q  <= s1_rev;
      s2_last_q <= s1_last_q;
      s2_r_q    <= s1_r;
      s2_data_q <= s1_data_q;
    end
    if (adv && s2_step && s2_last_q) begin
      out_crc_q <= s2_next;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.crc_value = out_crc_q;

`ifndef NO_ASSERTIONS
  // a fresh result always comes from the last byte of a run
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_step && s2_last_q && adv))
    else $error("result raised without a finishing byte");

  // input back-pressure only while a finished result is blocked
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && s2_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled without a blocked result");

  // a stalled step keeps its operand for the retry
  a_stall_holds_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> (s2_valid_q && $stable(s2_r_q) && $stable(s2_data_q)))
    else $error("stage 2 changed during a stall");

  // never touch a table while the pipe is held, and never both at once
  a_table_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fwd_en || rev_en) |-> (adv && !(fwd_en && rev_en)))
    else $error("illegal table access");
`endif

endmodule
